// ----- design/nctk_pkg.sv -----
// ----------------------------------------------------------------------------
// nctk_pkg
// shared types and constants for the nearest centroid top-k search core
// ----------------------------------------------------------------------------
package nctk_pkg;

  localparam int unsigned MaxCentroids = 256;
  localparam int unsigned MaxDims      = 128;
  localparam int unsigned MaxProbe     = 16;
  localparam int unsigned CoordBits    = 16;

  localparam int unsigned CidxW  = $clog2(MaxCentroids);
  localparam int unsigned DimW   = $clog2(MaxDims);
  localparam int unsigned ProbeW = $clog2(MaxProbe);
  localparam int unsigned DistW  = 40;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned AddrW  = CidxW + DimW;

  localparam logic [1:0] RegProbe     = 2'd0;
  localparam logic [1:0] RegCentroids = 2'd1;
  localparam logic [1:0] RegDims      = 2'd2;

  localparam logic OpCentroid = 1'b0;
  localparam logic OpQuery    = 1'b1;

  // command handed from the front end to the search engine
  typedef struct packed {
    logic             is_query;
    logic [CidxW-1:0] cidx;
    logic [DimW-1:0]  xidx;
    logic signed [CoordBits-1:0] value;
    logic             start;
  } cmd_t;

endpackage

// ----- design/nctk_front.sv -----
// ----------------------------------------------------------------------------
// nctk_front
// accepts items, holds the registers, classifies items into commands
// ----------------------------------------------------------------------------
module nctk_front import nctk_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        op_i,
  input  logic [CidxW-1:0]            centroid_index_i,
  input  logic [DimW-1:0]             coord_index_i,
  input  logic signed [CoordBits-1:0] coord_value_i,
  output logic                        cmd_valid_o,
  output cmd_t                        cmd_o,
  input  logic                        cmd_ready_i,
  output logic [ProbeW:0]             k_o,
  output logic [CidxW:0]              n_o,
  output logic [DimW:0]               dims_o
);

  logic [4:0] probe_q;
  logic [8:0] cent_q;
  logic [7:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= 5'd1;
      cent_q  <= 9'd1;
      dims_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegProbe:     probe_q <= cfg_data_i[4:0];
        RegCentroids: cent_q  <= cfg_data_i[8:0];
        RegDims:      dims_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [ProbeW:0] kc;
  logic [CidxW:0]  nc;
  logic [DimW:0]   dc;

  always_comb begin
    kc = (probe_q == '0) ? (ProbeW+1)'(1) :
         (32'(probe_q) > MaxProbe) ? (ProbeW+1)'(MaxProbe) : (ProbeW+1)'(probe_q);
    nc = (cent_q == '0) ? (CidxW+1)'(1) :
         (32'(cent_q) > MaxCentroids) ? (CidxW+1)'(MaxCentroids) : (CidxW+1)'(cent_q);
    dc = (dims_q == '0) ? (DimW+1)'(1) :
         (32'(dims_q) > MaxDims) ? (DimW+1)'(MaxDims) : (DimW+1)'(dims_q);
  end

  assign n_o    = nc;
  assign dims_o = dc;
  assign k_o    = (32'(kc) > 32'(nc)) ? (ProbeW+1)'(nc) : kc;

  // two-entry command queue
  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o      = (cnt_q == 2'd2);
  assign wr          = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd          = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  cmd_t cmd_in;
  always_comb begin
    cmd_in.is_query = (op_i == OpQuery);
    cmd_in.cidx     = centroid_index_i;
    cmd_in.xidx     = coord_index_i;
    cmd_in.value    = coord_value_i;
    cmd_in.start    = (op_i == OpQuery) && ({1'b0, coord_index_i} == dc - 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (wr) fifo_q[wp_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- design/nctk_back.sv -----
// ----------------------------------------------------------------------------
// nctk_back
// stores vectors, walks centroids with one multiplier, keeps a sorted list
// ----------------------------------------------------------------------------
module nctk_back import nctk_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  cmd_t            cmd_i,
  output logic            cmd_ready_o,
  input  logic [ProbeW:0] k_i,
  input  logic [CidxW:0]  n_i,
  input  logic [DimW:0]   dims_i,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [CidxW-1:0] cluster_index_o,
  output logic [DistW-1:0] squared_distance_o,
  output logic [ProbeW-1:0] rank_o,
  output logic            last_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StAcc    = 4'b0010,
    StInsert = 4'b0100,
    StEmit   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordBits-1:0] cmem [MaxCentroids*MaxDims];
  logic signed [CoordBits-1:0] qmem [MaxDims];

  logic [CidxW:0]  c_q;
  logic [DimW:0]   t_q;
  logic [ProbeW:0] k_q, cnt_q, r_q;
  logic [DimW:0]   dims_q;
  logic [CidxW:0]  n_q;
  logic [DistW-1:0] sum_q;
  logic            rd_v_q, sq_v_q;
  logic signed [CoordBits-1:0] crd_q, qrd_q;
  logic signed [CoordBits:0]   diff;
  logic signed [2*CoordBits+1:0] prod;
  logic [2*CoordBits+1:0]      sq_q;

  logic [DistW-1:0] bd_q [MaxProbe];
  logic [CidxW-1:0] bi_q [MaxProbe];

  assign cmd_ready_o = (state_q == StIdle);
  wire take = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i) begin
    if (take && !cmd_i.is_query)
      cmem[{cmd_i.cidx, cmd_i.xidx}] <= cmd_i.value;
    if (take && cmd_i.is_query) qmem[cmd_i.xidx] <= cmd_i.value;
    crd_q <= cmem[{c_q[CidxW-1:0], t_q[DimW-1:0]}];
    qrd_q <= qmem[t_q[DimW-1:0]];
  end

  assign diff = $signed({qrd_q[CoordBits-1], qrd_q}) -
                $signed({crd_q[CoordBits-1], crd_q});
  // product taken at full width so the square is never cut
  assign prod = diff * diff;
  always_ff @(posedge clk_i) begin
    sq_q <= $unsigned(prod);
  end

  // insertion position for the finished sum
  logic [ProbeW:0] pos;
  logic            ins;
  always_comb begin
    pos = cnt_q;
    for (int i = 0; i < MaxProbe; i++) begin
      if ((ProbeW+1)'(i) < cnt_q && bd_q[i] > sum_q && pos == cnt_q)
        pos = (ProbeW+1)'(i);
    end
    ins = (cnt_q < k_q) || (pos < k_q);
  end

  logic rd_fire;
  assign rd_fire = (state_q == StAcc) && !(t_q == dims_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (take && cmd_i.start) state_d = StAcc;
      StAcc:    if (!rd_fire && !rd_v_q && !sq_v_q) state_d = StInsert;
      StInsert: state_d = (c_q + 1'b1 == n_q) ? StEmit : StAcc;
      StEmit:   if (pop_i && r_q + 1'b1 == cnt_q) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      c_q <= '0; t_q <= '0; k_q <= '0; cnt_q <= '0; r_q <= '0;
      dims_q <= '0; n_q <= '0; sum_q <= '0; rd_v_q <= 1'b0; sq_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_fire;
      sq_v_q  <= rd_v_q;
      unique case (state_q)
        StIdle: if (take && cmd_i.start) begin
          c_q <= '0; t_q <= '0; cnt_q <= '0; r_q <= '0; sum_q <= '0;
          k_q <= k_i; n_q <= n_i; dims_q <= dims_i;
        end
        StAcc: begin
          if (rd_fire) t_q <= t_q + 1'b1;
          if (sq_v_q) sum_q <= sum_q + DistW'(sq_q);
        end
        StInsert: begin
          if (ins && cnt_q < k_q) cnt_q <= cnt_q + 1'b1;
          c_q <= c_q + 1'b1; t_q <= '0; sum_q <= '0;
        end
        StEmit: if (pop_i) r_q <= r_q + 1'b1;
        default: ;
      endcase
    end
  end

  // shift the list one place down from pos and drop the candidate in
  always_ff @(posedge clk_i) begin
    if (state_q == StInsert && ins) begin
      for (int i = 0; i < MaxProbe; i++) begin
        if ((ProbeW+1)'(i) > pos) begin
          bd_q[i] <= bd_q[(i > 0) ? i - 1 : 0];
          bi_q[i] <= bi_q[(i > 0) ? i - 1 : 0];
        end else if ((ProbeW+1)'(i) == pos) begin
          bd_q[i] <= sum_q;
          bi_q[i] <= c_q[CidxW-1:0];
        end
      end
    end
  end

  assign empty_o            = (state_q != StEmit);
  assign cluster_index_o    = bi_q[r_q[ProbeW-1:0]];
  assign squared_distance_o = bd_q[r_q[ProbeW-1:0]];
  assign rank_o             = r_q[ProbeW-1:0];
  assign last_o             = (r_q + 1'b1 == cnt_q);

endmodule

// ----- design/nearest_centroid_top_k_core.sv -----
// centroid writes and non-final query coordinates pass through the queue and are stored
// a final query coordinate starts a search over all n centroids, one coordinate
// per cycle through one subtract-square-accumulate path, then one result per pop
// a two-entry queue parts the input side from the search engine
// reset clears registers to 1, empties the queue and the list; memories are not cleared
module nearest_centroid_top_k_core import nctk_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        op_i,
  input  logic [CidxW-1:0]            centroid_index_i,
  input  logic [DimW-1:0]             coord_index_i,
  input  logic signed [CoordBits-1:0] coord_value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [CidxW-1:0]            cluster_index_o,
  output logic [DistW-1:0]            squared_distance_o,
  output logic [ProbeW-1:0]           rank_o,
  output logic                        last_o
);

  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;
  logic [ProbeW:0] k;
  logic [CidxW:0]  n;
  logic [DimW:0]   dims;

  nctk_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .full_o(full), .op_i, .centroid_index_i, .coord_index_i,
    .coord_value_i, .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready),
    .k_o(k), .n_o(n), .dims_o(dims)
  );

  nctk_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .k_i(k), .n_i(n), .dims_i(dims), .empty_o(empty), .pop_i(pop),
    .cluster_index_o, .squared_distance_o, .rank_o, .last_o
  );

endmodule

// ----- design/nctk_checker.sv -----
// ----------------------------------------------------------------------------
// nctk_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module nctk_checker import nctk_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [ProbeW-1:0] rank_o,
  input logic              last_o
);

  // a new result group starts at rank zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> rank_o == '0) else $error("group not at rank zero");

  // after a non-last pop the next result follows with rank plus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (!empty && rank_o == $past(rank_o) + 1'b1))
    else $error("rank not consecutive");

  // popping the last result ends the group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_o) |=> empty) else $error("output not empty after last");

endmodule

bind nearest_centroid_top_k_core nctk_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .rank_o, .last_o
);
